### sv/psnd_pkg.sv
// Shared types and constants for the point-to-segment nearest distance block.
package psnd_pkg;

  localparam int CoordW   = 24;              // input / output coordinates
  localparam int DiffW    = CoordW + 1;      // coordinate differences
  localparam int ProdW    = 2 * DiffW;       // products of two differences
  localparam int SumW     = ProdW + 1;       // sum of two products
  localparam int DenW     = ProdW;           // |B-A|^2 and a non-negative num
  localparam int MagW     = DiffW;           // |dx|, |dy| and the quotients
  localparam int RemW     = DenW + 2;        // divider partial remainder
  localparam int DivSteps = MagW;            // one quotient digit per stage
  localparam int SqrtW    = 2 * ((SumW + 1) / 2);  // even root operand width
  localparam int RootW    = SqrtW / 2;
  localparam int SRemW    = RootW + 3;
  localparam int DistW    = 25;
  localparam int PreSt    = 4;               // difference, product, sum, decide
  localparam int PostSt   = 4;               // nearest, difference, square, sum
  localparam int Depth    = PreSt + DivSteps + PostSt + RootW;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [DiffW-1:0]  diff_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [SumW-1:0]   sum_t;
  typedef logic        [DenW-1:0]   den_t;
  typedef logic        [MagW-1:0]   mag_t;
  typedef logic        [RemW-1:0]   rem_t;
  typedef logic        [SqrtW-1:0]  sqx_t;
  typedef logic        [RootW-1:0]  root_t;
  typedef logic        [SRemW-1:0]  srem_t;
  typedef logic        [DistW-1:0]  dist_t;

  typedef struct packed {
    coord_t px, py, ax, ay, bx, by;
  } pts_t;

endpackage

### sv/psnd_if.sv
// Query and result channel interfaces.
interface psnd_query_if;
  import psnd_pkg::*;
  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  coord_t seg_start_x;
  coord_t seg_start_y;
  coord_t seg_end_x;
  coord_t seg_end_y;
  modport source(output valid, point_x, point_y, seg_start_x, seg_start_y,
                 seg_end_x, seg_end_y, input ready);
  modport sink(input valid, point_x, point_y, seg_start_x, seg_start_y,
               seg_end_x, seg_end_y, output ready);
endinterface

interface psnd_result_if;
  import psnd_pkg::*;
  logic   valid;
  logic   ready;
  coord_t nearest_x;
  coord_t nearest_y;
  dist_t  dist_res;
  logic   zero_length;
  modport source(output valid, nearest_x, nearest_y, dist_res, zero_length,
                 input ready);
  modport sink(input valid, nearest_x, nearest_y, dist_res, zero_length,
               output ready);
endinterface

### sv/point_segment_nearest_distance.sv
// Nearest point on a 2-D segment and the distance to it, fully pipelined.
//
// Channels: query takes P, A (start) and B (end) in signed Q12.12; result
// returns the nearest point on segment AB, floor of the distance in Q13.12,
// and a flag raised when A equals B (the nearest point is then A).
// Between an accepted request and its result, four stages form differences,
// products, num/den and the endpoint decision, 25 divider stages produce one
// quotient digit each for both axes, four stages form the nearest point and
// its squared distance, and 26 square-root stages produce one root bit each.
// Throughput is one request per cycle unless the receiver stalls; every
// stage holds one request.
// When the receiver stalls, the whole pipeline holds and query.ready drops;
// the result register keeps its request until taken, nothing is dropped.
// Reset clears every valid bit; data registers are not reset. There is no
// configuration and no state carried from one request to the next.
module point_segment_nearest_distance (
  input logic clk,
  input logic rst,
  psnd_query_if.sink    query,
  psnd_result_if.source result
);
  import psnd_pkg::*;

  typedef struct packed {
    pts_t  p;
    diff_t dx, dy, ux, uy, wx, wy;
  } st1_t;

  typedef struct packed {
    pts_t  p;
    diff_t dx, dy;
    prod_t udx, udy, ddx, ddy, uux, uuy, wwx, wwy;
  } st2_t;

  typedef struct packed {
    pts_t  p;
    diff_t dx, dy;
    sum_t  num;
    sum_t  den;
    sum_t  da, db;
  } st3_t;

  typedef struct packed {
    pts_t p;
    den_t num, den;
    mag_t mag_x, mag_y;
    logic neg_x, neg_y, proj, sel_a, zero;
    rem_t r_x, r_y;
    mag_t q_x, q_y;
  } div_t;

  typedef struct packed {
    coord_t px, py, nx, ny;
    logic   zero;
  } nst_t;

  typedef struct packed {
    coord_t nx, ny;
    logic   zero;
    diff_t  ex, ey;
  } est_t;

  typedef struct packed {
    coord_t nx, ny;
    logic   zero;
    prod_t  sx, sy;
  } qst_t;

  typedef struct packed {
    coord_t nx, ny;
    logic   zero;
    sqx_t   x;
    srem_t  rem;
    root_t  root;
  } sq_t;

  logic [Depth-1:0] vld;
  logic             en;
  st1_t             s1;
  st2_t             s2;
  st3_t             s3;
  div_t             dv [DivSteps+1];
  nst_t             s5;
  est_t             s6;
  qst_t             s7;
  sq_t              sq [RootW+1];
  div_t             d0_next;
  nst_t             s5_next;

  // One quotient digit: shift in the next multiplier bit times num, then
  // take out den once or twice.
  function automatic void div_step(input rem_t r, input mag_t q, input logic b,
                                   input den_t num, input den_t den,
                                   output rem_t r_o, output mag_t q_o);
    rem_t             t;
    rem_t             d1;
    rem_t             d2;
    logic [MagW:0]    qs;
    t  = {r[RemW-2:0], 1'b0} + (b ? {2'b00, num} : '0);
    d1 = {2'b00, den};
    d2 = {1'b0, den, 1'b0};
    qs = {q, 1'b0};
    if (t >= d2) begin
      r_o = t - d2;
      qs  = qs + (MagW+1)'(2);
    end else if (t >= d1) begin
      r_o = t - d1;
      qs  = qs + (MagW+1)'(1);
    end else begin
      r_o = t;
    end
    q_o = qs[MagW-1:0];
  endfunction

  assign en          = !vld[Depth-1] || result.ready;
  assign query.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Depth-2:0], query.valid};
    end
  end

  // Differences.
  always_ff @(posedge clk) begin
    if (en) begin
      s1.p  <= '{query.point_x, query.point_y, query.seg_start_x,
                 query.seg_start_y, query.seg_end_x, query.seg_end_y};
      s1.dx <= DiffW'(query.seg_end_x) - DiffW'(query.seg_start_x);
      s1.dy <= DiffW'(query.seg_end_y) - DiffW'(query.seg_start_y);
      s1.ux <= DiffW'(query.point_x) - DiffW'(query.seg_start_x);
      s1.uy <= DiffW'(query.point_y) - DiffW'(query.seg_start_y);
      s1.wx <= DiffW'(query.point_x) - DiffW'(query.seg_end_x);
      s1.wy <= DiffW'(query.point_y) - DiffW'(query.seg_end_y);
    end
  end

  // Products.
  always_ff @(posedge clk) begin
    if (en) begin
      s2.p   <= s1.p;
      s2.dx  <= s1.dx;
      s2.dy  <= s1.dy;
      s2.udx <= ProdW'(s1.ux) * ProdW'(s1.dx);
      s2.udy <= ProdW'(s1.uy) * ProdW'(s1.dy);
      s2.ddx <= ProdW'(s1.dx) * ProdW'(s1.dx);
      s2.ddy <= ProdW'(s1.dy) * ProdW'(s1.dy);
      s2.uux <= ProdW'(s1.ux) * ProdW'(s1.ux);
      s2.uuy <= ProdW'(s1.uy) * ProdW'(s1.uy);
      s2.wwx <= ProdW'(s1.wx) * ProdW'(s1.wx);
      s2.wwy <= ProdW'(s1.wy) * ProdW'(s1.wy);
    end
  end

  // Dot product, squared length, squared endpoint distances.
  always_ff @(posedge clk) begin
    if (en) begin
      s3.p   <= s2.p;
      s3.dx  <= s2.dx;
      s3.dy  <= s2.dy;
      s3.num <= SumW'(s2.udx) + SumW'(s2.udy);
      s3.den <= SumW'(s2.ddx) + SumW'(s2.ddy);
      s3.da  <= SumW'(s2.uux) + SumW'(s2.uuy);
      s3.db  <= SumW'(s2.wwx) + SumW'(s2.wwy);
    end
  end

  // Decide projection or endpoint, set up the divider.
  always_comb begin
    d0_next       = '0;
    d0_next.p     = s3.p;
    d0_next.num   = s3.num[DenW-1:0];
    d0_next.den   = s3.den[DenW-1:0];
    d0_next.neg_x = s3.dx[DiffW-1];
    d0_next.neg_y = s3.dy[DiffW-1];
    d0_next.mag_x = s3.dx[DiffW-1] ? MagW'(-s3.dx) : MagW'(s3.dx);
    d0_next.mag_y = s3.dy[DiffW-1] ? MagW'(-s3.dy) : MagW'(s3.dy);
    d0_next.zero  = (s3.den == '0);
    d0_next.proj  = !d0_next.zero && !s3.num[SumW-1] && (s3.num <= s3.den);
    d0_next.sel_a = d0_next.zero || (s3.da < s3.db);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0] <= d0_next;
    end
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    always_ff @(posedge clk) begin
      rem_t rx, ry;
      mag_t qx, qy;
      div_t nxt;
      if (en) begin
        div_step(dv[k].r_x, dv[k].q_x, dv[k].mag_x[DivSteps-1-k],
                 dv[k].num, dv[k].den, rx, qx);
        div_step(dv[k].r_y, dv[k].q_y, dv[k].mag_y[DivSteps-1-k],
                 dv[k].num, dv[k].den, ry, qy);
        nxt      = dv[k];
        nxt.r_x  = rx;
        nxt.r_y  = ry;
        nxt.q_x  = qx;
        nxt.q_y  = qy;
        dv[k+1] <= nxt;
      end
    end
  end

  // Nearest point.
  always_comb begin
    logic signed [DiffW:0] ax, ay, qx, qy, tx, ty;
    ax = (DiffW+1)'(dv[DivSteps].p.ax);
    ay = (DiffW+1)'(dv[DivSteps].p.ay);
    qx = (DiffW+1)'(dv[DivSteps].q_x);
    qy = (DiffW+1)'(dv[DivSteps].q_y);
    tx = dv[DivSteps].neg_x ? ax - qx : ax + qx;
    ty = dv[DivSteps].neg_y ? ay - qy : ay + qy;
    s5_next.px   = dv[DivSteps].p.px;
    s5_next.py   = dv[DivSteps].p.py;
    s5_next.zero = dv[DivSteps].zero;
    priority if (dv[DivSteps].proj) begin
      s5_next.nx = tx[CoordW-1:0];
      s5_next.ny = ty[CoordW-1:0];
    end else if (dv[DivSteps].sel_a) begin
      s5_next.nx = dv[DivSteps].p.ax;
      s5_next.ny = dv[DivSteps].p.ay;
    end else begin
      s5_next.nx = dv[DivSteps].p.bx;
      s5_next.ny = dv[DivSteps].p.by;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5      <= s5_next;
      s6.nx   <= s5.nx;
      s6.ny   <= s5.ny;
      s6.zero <= s5.zero;
      s6.ex   <= DiffW'(s5.px) - DiffW'(s5.nx);
      s6.ey   <= DiffW'(s5.py) - DiffW'(s5.ny);
      s7.nx   <= s6.nx;
      s7.ny   <= s6.ny;
      s7.zero <= s6.zero;
      s7.sx   <= ProdW'(s6.ex) * ProdW'(s6.ex);
      s7.sy   <= ProdW'(s6.ey) * ProdW'(s6.ey);
      sq[0].nx   <= s7.nx;
      sq[0].ny   <= s7.ny;
      sq[0].zero <= s7.zero;
      sq[0].x    <= SqrtW'(s7.sx) + SqrtW'(s7.sy);
      sq[0].rem  <= '0;
      sq[0].root <= '0;
    end
  end

  // Square root, one root bit per stage, top operand bits first.
  for (genvar k = 0; k < RootW; k++) begin : g_sqrt
    localparam int J = RootW - 1 - k;
    always_ff @(posedge clk) begin
      srem_t r2, trial;
      sq_t   nxt;
      r2    = {sq[k].rem[SRemW-3:0], sq[k].x[2*J+1:2*J]};
      trial = SRemW'({sq[k].root, 2'b01});
      nxt   = sq[k];
      if (r2 >= trial) begin
        nxt.rem  = r2 - trial;
        nxt.root = {sq[k].root[RootW-2:0], 1'b1};
      end else begin
        nxt.rem  = r2;
        nxt.root = {sq[k].root[RootW-2:0], 1'b0};
      end
      if (en) begin
        sq[k+1] <= nxt;
      end
    end
  end

  assign result.valid       = vld[Depth-1];
  assign result.nearest_x   = sq[RootW].nx;
  assign result.nearest_y   = sq[RootW].ny;
  assign result.dist_res    = sq[RootW].root[DistW-1:0];
  assign result.zero_length = sq[RootW].zero;

`ifndef SYNTH
  // Root is the floor of the square root of the squared distance.
  a_root_floor: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (64'(sq[RootW].root) * 64'(sq[RootW].root) <= 64'(sq[RootW].x)) &&
      ((64'(sq[RootW].root) + 64'd1) * (64'(sq[RootW].root) + 64'd1) > 64'(sq[RootW].x)))
    else $error("square root result out of range");

  // A projected quotient never exceeds the axis length.
  a_quot_bound: assert property (@(posedge clk) disable iff (rst)
    vld[PreSt+DivSteps-1] && dv[DivSteps].proj |->
      (dv[DivSteps].q_x <= dv[DivSteps].mag_x) && (dv[DivSteps].q_y <= dv[DivSteps].mag_y))
    else $error("divider quotient exceeds axis magnitude");

  // A zero-length segment never takes the projection path.
  a_zero_proj: assert property (@(posedge clk) disable iff (rst)
    vld[PreSt-1] && dv[0].zero |-> !dv[0].proj && dv[0].sel_a)
    else $error("zero-length segment routed to projection");

  // Nothing leaves the pipeline right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result.valid)
    else $error("result valid right after reset");
`endif

endmodule
